@@ hdl/mjss_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mjss_pkg
// Shared types, constants and helpers of the minimum-jerk segment sampler.
// ----------------------------------------------------------------------------
package mjss_pkg;

   // item action codes
   localparam logic ACT_LOAD   = 1'b0;
   localparam logic ACT_SAMPLE = 1'b1;

   // configuration register indexes
   localparam logic [2:0] CSR_NOMINAL_SPEED    = 3'd0;
   localparam logic [2:0] CSR_MAX_ACCEL        = 3'd1;
   localparam logic [2:0] CSR_MAX_HEADING_RATE = 3'd2;
   localparam logic [2:0] CSR_MIN_SEG_TIME     = 3'd3;
   localparam logic [2:0] CSR_MAX_SEG_TIME     = 3'd4;
   localparam logic [2:0] CSR_HEADING_EN       = 3'd5;

   localparam logic [31:0] RATE_FLOOR  = 32'd66;
   localparam logic [31:0] DUR_FLOOR   = 32'd13107;
   localparam logic [30:0] ONE_Q30     = 31'h4000_0000;
   localparam logic signed [16:0] PI_Q12     = 17'sd12868;
   localparam logic signed [16:0] TWO_PI_Q12 = 17'sd25736;

   // operand layout of the divide / root unit
   localparam int DSU_OP_W  = 66;
   localparam int DSU_ACC_W = 62;
   localparam int DSU_REM_W = 35;

   typedef struct packed {
      logic                 start;
      logic                 sqrt_mode;
      logic [DSU_OP_W-1:0]  operand;
      logic [31:0]          divisor;
      logic [6:0]           steps;
   } dsu_cmd_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SQ_ISSUE,
      ST_SQ_ACC,
      ST_DIST,
      ST_SPD,
      ST_ACC_Q,
      ST_ACC_R,
      ST_YAW,
      ST_FIN,
      ST_TAU,
      ST_POW_ISSUE,
      ST_POW_CAP,
      ST_BLEND,
      ST_LERP_ISSUE,
      ST_LERP_CAP,
      ST_DONE
   } state_type;

   // fold a yaw difference into plus or minus pi; one step covers all inputs
   function automatic logic signed [16:0] wrap_yaw(input logic signed [16:0] d);
      logic signed [16:0] r;
      if (d > PI_Q12) begin
         r = d - TWO_PI_Q12;
      end else if (d < -PI_Q12) begin
         r = d + TWO_PI_Q12;
      end else begin
         r = d;
      end
      return r;
   endfunction

endpackage

@@ hdl/min_jerk_segment_sampler_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// min_jerk_segment_sampler_unit
// Minimum-jerk segment sampler: loads a waypoint pair, sizes the segment and
// samples position and yaw along a quintic blend.
// ----------------------------------------------------------------------------
// One transaction at a time. A sample-only transaction runs the time-fraction
// division, the powers and the blend; a load first adds the squares, distance
// root, two divisions, the acceleration root and, with heading blend enabled, the
// yaw division. The roots and divisions run one bit per cycle on a single shared
// divide/root unit, and all products go through one shared 33 x 33
// multiplier. A finished result waits in the response register while the
// next request is accepted.
module min_jerk_segment_sampler_unit (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic               req_action,
   input  logic [31:0]        req_sample_time,
   input  logic signed [31:0] req_start_x,
   input  logic signed [31:0] req_start_y,
   input  logic signed [31:0] req_start_z,
   input  logic signed [14:0] req_start_heading,
   input  logic signed [31:0] req_goal_x,
   input  logic signed [31:0] req_goal_y,
   input  logic signed [31:0] req_goal_z,
   input  logic signed [14:0] req_goal_heading,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [31:0] rsp_pos_x,
   output logic signed [31:0] rsp_pos_y,
   output logic signed [31:0] rsp_pos_z,
   output logic signed [15:0] rsp_heading_out,
   output logic               rsp_finished,
   output logic               rsp_segment_loaded,
   output logic [31:0]        rsp_duration_out,
   input  logic               csr_wr_en,
   input  logic [2:0]         csr_index,
   input  logic [31:0]        csr_wr_data
);

   // configuration
   logic [31:0] speed_ff, accel_ff, yrate_ff, tmin_ff, tmax_ff;
   logic        hen_ff;

   // segment state
   logic [31:0] seg_s_ff [3];
   logic [31:0] seg_g_ff [3];
   logic [31:0] seg_s_in [3];
   logic [31:0] seg_g_in [3];
   logic [15:0] seg_sh_ff, seg_sh_in, seg_gh_ff, seg_gh_in;
   logic [31:0] dur_ff, dur_in;
   logic        valid_ff, valid_in;
   logic        interp_ff, interp_in;

   // working registers
   mjss_pkg::state_type state_ff, state_in;
   logic        launched_ff, launched_in;
   logic [31:0] t_ff, t_in;
   logic [1:0]  k_ff, k_in;
   logic [65:0] sum_ff, sum_in;
   logic [32:0] dist_ff, dist_in;
   logic [48:0] best_ff, best_in;
   logic [48:0] aq_ff, aq_in;
   logic [30:0] tau_ff, tau_in, pw_ff, pw_in, t3_ff, t3_in, t4_ff, t4_in;
   logic [30:0] blend_ff, blend_in;
   logic [31:0] res_ff [4];
   logic [31:0] res_in [4];

   // response registers
   logic        rsp_valid_ff, rsp_valid_in;
   logic [31:0] rx_ff, rx_in, ry_ff, ry_in, rz_ff, rz_in, rdur_ff, rdur_in;
   logic [15:0] rh_ff, rh_in;
   logic        rfin_ff, rfin_in, rld_ff, rld_in;

   // shared units
   mjss_pkg::dsu_cmd_type dsu_cmd;
   logic                  dsu_done;
   logic [mjss_pkg::DSU_ACC_W-1:0] dsu_result;
   logic [32:0] mul_a, mul_b;
   logic [65:0] mul_prod;

   mjss_divsqrt u_divsqrt (
      .clock  (clock),
      .reset  (reset),
      .cmd    (dsu_cmd),
      .done   (dsu_done),
      .result (dsu_result)
   );

   mjss_mul u_mul (
      .clock (clock),
      .op_a  (mul_a),
      .op_b  (mul_b),
      .prod  (mul_prod)
   );

   // datapath helpers
   logic signed [16:0] yaw_d;
   logic [16:0]        yaw_mag;
   logic signed [32:0] delta [4];
   logic signed [32:0] start33 [4];
   logic [32:0]        dmag [4];
   logic [31:0]        sp_eff, ac_eff, yr_eff;
   logic [31:0]        ct;
   logic [35:0]        e3, e4, e5, blend_raw;
   logic [30:0]        blend_cl;
   logic [33:0]        cand_acc;
   logic [48:0]        fin_b;
   logic [32:0]        lerp_q;
   logic signed [33:0] lerp_sq, lerp_res;
   logic [30:0]        pow_p;

   always_comb begin
      yaw_d   = mjss_pkg::wrap_yaw(17'({seg_gh_ff[15], seg_gh_ff})
                                 - 17'({seg_sh_ff[15], seg_sh_ff}));
      yaw_mag = yaw_d[16] ? 17'(-yaw_d) : 17'(yaw_d);
      for (int i = 0; i < 3; i++) begin
         delta[i]   = $signed({seg_g_ff[i][31], seg_g_ff[i]})
                    - $signed({seg_s_ff[i][31], seg_s_ff[i]});
         start33[i] = $signed({seg_s_ff[i][31], seg_s_ff[i]});
      end
      delta[3]   = 33'(yaw_d);
      start33[3] = 33'($signed(seg_sh_ff));
      for (int i = 0; i < 4; i++) begin
         dmag[i] = delta[i][32] ? 33'(-delta[i]) : 33'(delta[i]);
      end

      sp_eff = (speed_ff < mjss_pkg::RATE_FLOOR) ? mjss_pkg::RATE_FLOOR : speed_ff;
      ac_eff = (accel_ff < mjss_pkg::RATE_FLOOR) ? mjss_pkg::RATE_FLOOR : accel_ff;
      yr_eff = (yrate_ff < mjss_pkg::RATE_FLOOR) ? mjss_pkg::RATE_FLOOR : yrate_ff;
      ct     = (t_ff < dur_ff) ? t_ff : dur_ff;

      e3 = {5'd0, t3_ff};
      e4 = {5'd0, t4_ff};
      e5 = {5'd0, pw_ff};
      blend_raw = (e3 << 3) + (e3 << 1) - ((e4 << 4) - e4) + (e5 << 2) + (e5 << 1);
      if (blend_raw[35]) begin
         blend_cl = '0;
      end else if (blend_raw > {5'd0, mjss_pkg::ONE_Q30}) begin
         blend_cl = mjss_pkg::ONE_Q30;
      end else begin
         blend_cl = blend_raw[30:0];
      end

      cand_acc = {dsu_result[32:0], 1'b0};

      fin_b = best_ff;
      if (tmax_ff != 32'd0 && fin_b > {17'd0, tmax_ff}) begin
         fin_b = {17'd0, tmax_ff};
      end
      if (fin_b > 49'h0_FFFF_FFFF) begin
         fin_b = 49'h0_FFFF_FFFF;
      end
      if (fin_b < {17'd0, mjss_pkg::DUR_FLOOR}) begin
         fin_b = {17'd0, mjss_pkg::DUR_FLOOR};
      end

      pow_p    = mul_prod[60:30];
      lerp_q   = mul_prod[62:30];
      lerp_sq  = delta[k_ff][32] ? -$signed({1'b0, lerp_q}) : $signed({1'b0, lerp_q});
      lerp_res = $signed({start33[k_ff][32], start33[k_ff]}) + lerp_sq;
   end

   // sequencer
   always_comb begin
      state_in    = state_ff;
      launched_in = launched_ff;
      t_in        = t_ff;
      k_in        = k_ff;
      sum_in      = sum_ff;
      dist_in     = dist_ff;
      best_in     = best_ff;
      aq_in       = aq_ff;
      tau_in      = tau_ff;
      pw_in       = pw_ff;
      t3_in       = t3_ff;
      t4_in       = t4_ff;
      blend_in    = blend_ff;
      res_in      = res_ff;
      seg_s_in    = seg_s_ff;
      seg_g_in    = seg_g_ff;
      seg_sh_in   = seg_sh_ff;
      seg_gh_in   = seg_gh_ff;
      dur_in      = dur_ff;
      valid_in    = valid_ff;
      interp_in   = interp_ff;

      rsp_valid_in = rsp_valid_ff & ~rsp_ready;
      rx_in   = rx_ff;
      ry_in   = ry_ff;
      rz_in   = rz_ff;
      rh_in   = rh_ff;
      rfin_in = rfin_ff;
      rld_in  = rld_ff;
      rdur_in = rdur_ff;

      req_ready = (state_ff == mjss_pkg::ST_IDLE);

      dsu_cmd.start     = 1'b0;
      dsu_cmd.sqrt_mode = 1'b0;
      dsu_cmd.operand   = '0;
      dsu_cmd.divisor   = '0;
      dsu_cmd.steps     = '0;
      mul_a = '0;
      mul_b = '0;

      unique case (state_ff)
         mjss_pkg::ST_IDLE: begin
            if (req_valid) begin
               t_in = req_sample_time;
               if (req_action == mjss_pkg::ACT_LOAD) begin
                  seg_s_in[0] = req_start_x;
                  seg_s_in[1] = req_start_y;
                  seg_s_in[2] = req_start_z;
                  seg_g_in[0] = req_goal_x;
                  seg_g_in[1] = req_goal_y;
                  seg_g_in[2] = req_goal_z;
                  seg_sh_in   = 16'(req_start_heading);
                  seg_gh_in   = 16'(req_goal_heading);
                  interp_in   = hen_ff;
                  k_in        = '0;
                  sum_in      = '0;
                  state_in    = mjss_pkg::ST_SQ_ISSUE;
               end else if (valid_ff) begin
                  state_in = mjss_pkg::ST_TAU;
               end else begin
                  state_in = mjss_pkg::ST_DONE;
               end
            end
         end
         mjss_pkg::ST_SQ_ISSUE: begin
            mul_a    = dmag[k_ff];
            mul_b    = dmag[k_ff];
            state_in = mjss_pkg::ST_SQ_ACC;
         end
         mjss_pkg::ST_SQ_ACC: begin
            sum_in = sum_ff + mul_prod;
            k_in   = k_ff + 2'd1;
            state_in = (k_ff == 2'd2) ? mjss_pkg::ST_DIST : mjss_pkg::ST_SQ_ISSUE;
         end
         mjss_pkg::ST_DIST: begin
            dsu_cmd.sqrt_mode = 1'b1;
            dsu_cmd.operand   = sum_ff;
            dsu_cmd.steps     = 7'd33;
            if (!launched_ff) begin
               dsu_cmd.start = 1'b1;
               launched_in   = 1'b1;
            end else if (dsu_done) begin
               launched_in = 1'b0;
               dist_in     = dsu_result[32:0];
               state_in    = mjss_pkg::ST_SPD;
            end
         end
         mjss_pkg::ST_SPD: begin
            dsu_cmd.operand = {dist_ff, 16'd0, 17'd0};
            dsu_cmd.divisor = sp_eff;
            dsu_cmd.steps   = 7'd49;
            if (!launched_ff) begin
               dsu_cmd.start = 1'b1;
               launched_in   = 1'b1;
            end else if (dsu_done) begin
               launched_in = 1'b0;
               best_in = (dsu_result[48:0] > {17'd0, tmin_ff}) ? dsu_result[48:0]
                                                               : {17'd0, tmin_ff};
               state_in = mjss_pkg::ST_ACC_Q;
            end
         end
         mjss_pkg::ST_ACC_Q: begin
            dsu_cmd.operand = {dist_ff, 16'd0, 17'd0};
            dsu_cmd.divisor = ac_eff;
            dsu_cmd.steps   = 7'd49;
            if (!launched_ff) begin
               dsu_cmd.start = 1'b1;
               launched_in   = 1'b1;
            end else if (dsu_done) begin
               launched_in = 1'b0;
               aq_in       = dsu_result[48:0];
               state_in    = mjss_pkg::ST_ACC_R;
            end
         end
         mjss_pkg::ST_ACC_R: begin
            dsu_cmd.sqrt_mode = 1'b1;
            dsu_cmd.operand   = {1'b0, aq_ff, 16'd0};
            dsu_cmd.steps     = 7'd33;
            if (!launched_ff) begin
               dsu_cmd.start = 1'b1;
               launched_in   = 1'b1;
            end else if (dsu_done) begin
               launched_in = 1'b0;
               if ({15'd0, cand_acc} > best_ff) begin
                  best_in = {15'd0, cand_acc};
               end
               state_in = interp_ff ? mjss_pkg::ST_YAW : mjss_pkg::ST_FIN;
            end
         end
         mjss_pkg::ST_YAW: begin
            dsu_cmd.operand = {yaw_mag[13:0], 20'd0, 32'd0};
            dsu_cmd.divisor = yr_eff;
            dsu_cmd.steps   = 7'd34;
            if (!launched_ff) begin
               dsu_cmd.start = 1'b1;
               launched_in   = 1'b1;
            end else if (dsu_done) begin
               launched_in = 1'b0;
               if ({15'd0, dsu_result[33:0]} > best_ff) begin
                  best_in = {15'd0, dsu_result[33:0]};
               end
               state_in = mjss_pkg::ST_FIN;
            end
         end
         mjss_pkg::ST_FIN: begin
            dur_in   = fin_b[31:0];
            valid_in = 1'b1;
            state_in = mjss_pkg::ST_TAU;
         end
         mjss_pkg::ST_TAU: begin
            dsu_cmd.operand = {ct, 30'd0, 4'd0};
            dsu_cmd.divisor = dur_ff;
            dsu_cmd.steps   = 7'd62;
            if (!launched_ff) begin
               dsu_cmd.start = 1'b1;
               launched_in   = 1'b1;
            end else if (dsu_done) begin
               launched_in = 1'b0;
               tau_in      = dsu_result[30:0];
               k_in        = '0;
               state_in    = mjss_pkg::ST_POW_ISSUE;
            end
         end
         mjss_pkg::ST_POW_ISSUE: begin
            mul_a    = {2'b00, tau_ff};
            mul_b    = (k_ff == 2'd0) ? {2'b00, tau_ff} : {2'b00, pw_ff};
            state_in = mjss_pkg::ST_POW_CAP;
         end
         mjss_pkg::ST_POW_CAP: begin
            // powers two through five land in turn; keep three and four
            pw_in = pow_p;
            if (k_ff == 2'd1) begin
               t3_in = pow_p;
            end
            if (k_ff == 2'd2) begin
               t4_in = pow_p;
            end
            k_in     = k_ff + 2'd1;
            state_in = (k_ff == 2'd3) ? mjss_pkg::ST_BLEND : mjss_pkg::ST_POW_ISSUE;
         end
         mjss_pkg::ST_BLEND: begin
            blend_in = blend_cl;
            k_in     = '0;
            state_in = mjss_pkg::ST_LERP_ISSUE;
         end
         mjss_pkg::ST_LERP_ISSUE: begin
            mul_a    = dmag[k_ff];
            mul_b    = {2'b00, blend_ff};
            state_in = mjss_pkg::ST_LERP_CAP;
         end
         mjss_pkg::ST_LERP_CAP: begin
            res_in[k_ff] = lerp_res[31:0];
            k_in         = k_ff + 2'd1;
            state_in = (k_ff == 2'd3) ? mjss_pkg::ST_DONE : mjss_pkg::ST_LERP_ISSUE;
         end
         mjss_pkg::ST_DONE: begin
            // hold until the response register is free
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               if (valid_ff) begin
                  rx_in   = res_ff[0];
                  ry_in   = res_ff[1];
                  rz_in   = res_ff[2];
                  rh_in   = interp_ff ? res_ff[3][15:0] : seg_gh_ff;
                  rfin_in = (t_ff >= dur_ff);
                  rld_in  = 1'b1;
                  rdur_in = dur_ff;
               end else begin
                  rx_in   = '0;
                  ry_in   = '0;
                  rz_in   = '0;
                  rh_in   = '0;
                  rfin_in = 1'b1;
                  rld_in  = 1'b0;
                  rdur_in = '0;
               end
               state_in = mjss_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = mjss_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= mjss_pkg::ST_IDLE;
         launched_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         speed_ff     <= 32'd65536;
         accel_ff     <= 32'd131072;
         yrate_ff     <= 32'd65536;
         tmin_ff      <= '0;
         tmax_ff      <= '0;
         hen_ff       <= 1'b1;
         for (int i = 0; i < 3; i++) begin
            seg_s_ff[i] <= '0;
            seg_g_ff[i] <= '0;
         end
         seg_sh_ff <= '0;
         seg_gh_ff <= '0;
         dur_ff    <= '0;
         valid_ff  <= 1'b0;
         interp_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         launched_ff  <= launched_in;
         rsp_valid_ff <= rsp_valid_in;
         seg_s_ff     <= seg_s_in;
         seg_g_ff     <= seg_g_in;
         seg_sh_ff    <= seg_sh_in;
         seg_gh_ff    <= seg_gh_in;
         dur_ff       <= dur_in;
         valid_ff     <= valid_in;
         interp_ff    <= interp_in;
         if (csr_wr_en) begin
            unique case (csr_index)
               mjss_pkg::CSR_NOMINAL_SPEED:    speed_ff <= csr_wr_data;
               mjss_pkg::CSR_MAX_ACCEL:        accel_ff <= csr_wr_data;
               mjss_pkg::CSR_MAX_HEADING_RATE: yrate_ff <= csr_wr_data;
               mjss_pkg::CSR_MIN_SEG_TIME:     tmin_ff  <= csr_wr_data;
               mjss_pkg::CSR_MAX_SEG_TIME:     tmax_ff  <= csr_wr_data;
               mjss_pkg::CSR_HEADING_EN:       hen_ff   <= csr_wr_data[0];
               default: begin
               end
            endcase
         end
      end
      t_ff     <= t_in;
      k_ff     <= k_in;
      sum_ff   <= sum_in;
      dist_ff  <= dist_in;
      best_ff  <= best_in;
      aq_ff    <= aq_in;
      tau_ff   <= tau_in;
      pw_ff    <= pw_in;
      t3_ff    <= t3_in;
      t4_ff    <= t4_in;
      blend_ff <= blend_in;
      res_ff   <= res_in;
      rx_ff    <= rx_in;
      ry_ff    <= ry_in;
      rz_ff    <= rz_in;
      rh_ff    <= rh_in;
      rfin_ff  <= rfin_in;
      rld_ff   <= rld_in;
      rdur_ff  <= rdur_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_pos_x          = rx_ff;
   assign rsp_pos_y          = ry_ff;
   assign rsp_pos_z          = rz_ff;
   assign rsp_heading_out    = rh_ff;
   assign rsp_finished       = rfin_ff;
   assign rsp_segment_loaded = rld_ff;
   assign rsp_duration_out   = rdur_ff;

   // a loaded segment never has a duration below the floor
   assert property (@(posedge clock) disable iff (reset)
      valid_ff |-> (dur_ff >= mjss_pkg::DUR_FLOOR))
      else $error("segment duration below floor");

   // the shared unit only finishes while a division or root is waiting on it
   assert property (@(posedge clock) disable iff (reset)
      dsu_done |-> (launched_ff && (state_ff == mjss_pkg::ST_DIST ||
                    state_ff == mjss_pkg::ST_SPD || state_ff == mjss_pkg::ST_ACC_Q ||
                    state_ff == mjss_pkg::ST_ACC_R || state_ff == mjss_pkg::ST_YAW ||
                    state_ff == mjss_pkg::ST_TAU)))
      else $error("divide/root completion outside a waiting state");

   // blend weight stays within one
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == mjss_pkg::ST_LERP_ISSUE) |-> (blend_ff <= mjss_pkg::ONE_Q30))
      else $error("blend out of range");

   // an accepted transaction leaves the idle state
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (state_ff != mjss_pkg::ST_IDLE))
      else $error("accepted transaction dropped");

endmodule

@@ hdl/mjss_mul.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mjss_mul
// Shared unsigned 33 x 33 multiplier with a registered product.
// ----------------------------------------------------------------------------
module mjss_mul (
   input  logic        clock,
   input  logic [32:0] op_a,
   input  logic [32:0] op_b,
   output logic [65:0] prod
);

   logic [65:0] prod_ff;
   logic [65:0] prod_in;

   assign prod_in = {33'd0, op_a} * {33'd0, op_b};

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   assign prod = prod_ff;

endmodule

@@ hdl/mjss_divsqrt.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mjss_divsqrt
// Shared restoring divider and square root, one result bit per cycle.
// ----------------------------------------------------------------------------
module mjss_divsqrt (
   input  logic                              clock,
   input  logic                              reset,
   input  mjss_pkg::dsu_cmd_type             cmd,
   output logic                              done,
   output logic [mjss_pkg::DSU_ACC_W-1:0]    result
);

   logic [mjss_pkg::DSU_OP_W-1:0]  q_ff, q_in;
   logic [mjss_pkg::DSU_REM_W-1:0] r_ff, r_in;
   logic [mjss_pkg::DSU_ACC_W-1:0] acc_ff, acc_in;
   logic [6:0]                     cnt_ff, cnt_in;
   logic                           mode_ff, mode_in;
   logic [31:0]                    div_ff, div_in;
   logic                           done_ff, done_in;

   logic [mjss_pkg::DSU_REM_W+1:0] rp;
   logic [mjss_pkg::DSU_REM_W+1:0] trial;
   logic [mjss_pkg::DSU_REM_W+1:0] diff;
   logic                           ge;

   always_comb begin
      rp    = mode_ff ? {r_ff, q_ff[65:64]} : {1'b0, r_ff, q_ff[65]};
      trial = mode_ff ? {acc_ff[34:0], 2'b01} : {5'd0, div_ff};
      ge    = (rp >= trial);
      diff  = rp - trial;

      q_in    = q_ff;
      r_in    = r_ff;
      acc_in  = acc_ff;
      cnt_in  = cnt_ff;
      mode_in = mode_ff;
      div_in  = div_ff;
      done_in = 1'b0;

      if (cmd.start) begin
         q_in    = cmd.operand;
         r_in    = '0;
         acc_in  = '0;
         cnt_in  = cmd.steps;
         mode_in = cmd.sqrt_mode;
         div_in  = cmd.divisor;
      end else if (cnt_ff != 7'd0) begin
         r_in   = ge ? diff[mjss_pkg::DSU_REM_W-1:0] : rp[mjss_pkg::DSU_REM_W-1:0];
         acc_in = {acc_ff[mjss_pkg::DSU_ACC_W-2:0], ge};
         q_in   = mode_ff ? {q_ff[63:0], 2'b00} : {q_ff[64:0], 1'b0};
         cnt_in = cnt_ff - 7'd1;
         if (cnt_ff == 7'd1) begin
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
      q_ff    <= q_in;
      r_ff    <= r_in;
      acc_ff  <= acc_in;
      mode_ff <= mode_in;
      div_ff  <= div_in;
   end

   assign done   = done_ff;
   assign result = acc_ff;

endmodule

@@ dv/min_jerk_segment_sampler_unit_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// min_jerk_segment_sampler_unit_checker
// Watches the request, response and register ports of the segment sampler,
// predicts every response from a local copy of the segment and register
// state, and compares each response field by field in arrival order.
// ----------------------------------------------------------------------------
module min_jerk_segment_sampler_unit_checker (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_ready,
   input  logic               req_action,
   input  logic [31:0]        req_sample_time,
   input  logic signed [31:0] req_start_x,
   input  logic signed [31:0] req_start_y,
   input  logic signed [31:0] req_start_z,
   input  logic signed [14:0] req_start_heading,
   input  logic signed [31:0] req_goal_x,
   input  logic signed [31:0] req_goal_y,
   input  logic signed [31:0] req_goal_z,
   input  logic signed [14:0] req_goal_heading,
   input  logic               rsp_valid,
   input  logic               rsp_ready,
   input  logic signed [31:0] rsp_pos_x,
   input  logic signed [31:0] rsp_pos_y,
   input  logic signed [31:0] rsp_pos_z,
   input  logic signed [15:0] rsp_heading_out,
   input  logic               rsp_finished,
   input  logic               rsp_segment_loaded,
   input  logic [31:0]        rsp_duration_out,
   input  logic               csr_wr_en,
   input  logic [2:0]         csr_index,
   input  logic [31:0]        csr_wr_data,
   output int                 fail_count,
   output int                 pending
);

   typedef struct {
      logic signed [31:0] px;
      logic signed [31:0] py;
      logic signed [31:0] pz;
      logic signed [15:0] hd;
      logic               fin;
      logic               loaded;
      logic [31:0]        dur;
   } sample_type;

   sample_type sample_q[$];
   int         mismatches;

   // register copies
   logic [31:0] speed_reg, accel_reg, yaw_rate_reg, min_time_reg, max_time_reg;
   logic        heading_en_reg;

   // segment copy
   logic signed [31:0] seg_start[3];
   logic signed [31:0] seg_goal[3];
   logic signed [15:0] seg_start_yaw, seg_goal_yaw;
   logic [31:0]        seg_dur;
   logic               seg_live, seg_yaw_blend;

   function automatic logic [33:0] root_floor(input logic [67:0] v);
      logic [39:0] rem;
      logic [39:0] trial;
      logic [33:0] root;
      rem  = '0;
      root = '0;
      for (int i = 33; i >= 0; i--) begin
         rem   = {rem[37:0], v[2*i +: 2]};
         trial = {4'b0, root, 2'b01};
         if (rem >= trial) begin
            rem  = rem - trial;
            root = {root[32:0], 1'b1};
         end else begin
            root = {root[32:0], 1'b0};
         end
      end
      return root;
   endfunction

   function automatic longint fold_heading(input longint a);
      longint r;
      r = a;
      while (r > 12868) r = r - 25736;
      while (r < -12868) r = r + 25736;
      return r;
   endfunction

   function automatic longint blend_scale(input longint delta, input longint b);
      longint          p;
      longint unsigned mag;
      longint          q;
      p   = delta * b;
      mag = (p < 0) ? longint'(-p) : p;
      q   = longint'(mag >> 30);
      return (p < 0) ? -q : q;
   endfunction

   function automatic logic [31:0] segment_time(input longint s[3], input longint g[3],
                                                input longint sh, input longint gh);
      logic [67:0]     sumsq;
      logic [67:0]     mag;
      logic [33:0]     dist_root;
      longint unsigned dl, best, cand, q, sp, ac, yr, ym;
      longint          yd;
      sp    = (speed_reg < mjss_pkg::RATE_FLOOR) ? mjss_pkg::RATE_FLOOR : speed_reg;
      ac    = (accel_reg < mjss_pkg::RATE_FLOOR) ? mjss_pkg::RATE_FLOOR : accel_reg;
      yr    = (yaw_rate_reg < mjss_pkg::RATE_FLOOR) ? mjss_pkg::RATE_FLOOR : yaw_rate_reg;
      sumsq = '0;
      for (int k = 0; k < 3; k++) begin
         yd    = g[k] - s[k];
         mag   = (yd < 0) ? 68'(-yd) : 68'(yd);
         sumsq = sumsq + mag * mag;
      end
      dist_root = root_floor(sumsq);
      dl        = dist_root;
      best = min_time_reg;
      cand = (dl << 16) / sp;
      if (cand > best) best = cand;
      q    = (dl << 16) / ac;
      cand = 2 * longint'(root_floor(68'(q << 16)));
      if (cand > best) best = cand;
      if (heading_en_reg) begin
         yd   = fold_heading(gh - sh);
         ym   = (yd < 0) ? -yd : yd;
         cand = (ym << 20) / yr;
         if (cand > best) best = cand;
      end
      if (max_time_reg != 0 && best > max_time_reg) best = max_time_reg;
      if (best > 64'hFFFF_FFFF) best = 64'hFFFF_FFFF;
      if (best < mjss_pkg::DUR_FLOOR) best = mjss_pkg::DUR_FLOOR;
      return best[31:0];
   endfunction

   // update the segment on a load, then sample it
   function automatic sample_type predict_sample();
      sample_type      r;
      longint          s[3], g[3], sh, gh, tau, t2, t3, t4, t5, b, yaw;
      longint unsigned ct;
      s[0] = req_start_x; s[1] = req_start_y; s[2] = req_start_z;
      g[0] = req_goal_x;  g[1] = req_goal_y;  g[2] = req_goal_z;
      sh   = req_start_heading;
      gh   = req_goal_heading;
      if (req_action == mjss_pkg::ACT_LOAD) begin
         for (int k = 0; k < 3; k++) begin
            seg_start[k] = 32'(s[k]);
            seg_goal[k]  = 32'(g[k]);
         end
         seg_start_yaw = 16'(sh);
         seg_goal_yaw  = 16'(gh);
         seg_yaw_blend = heading_en_reg;
         seg_dur       = segment_time(s, g, sh, gh);
         seg_live      = 1'b1;
      end
      if (!seg_live) begin
         r = '{0, 0, 0, 0, 1'b1, 1'b0, 0};
         return r;
      end
      ct  = (req_sample_time < seg_dur) ? req_sample_time : seg_dur;
      tau = longint'((ct << 30) / seg_dur);
      t2  = (tau * tau) >> 30;
      t3  = (t2 * tau) >> 30;
      t4  = (t3 * tau) >> 30;
      t5  = (t4 * tau) >> 30;
      b   = 10 * t3 - 15 * t4 + 6 * t5;
      if (b < 0) b = 0;
      if (b > (64'sd1 <<< 30)) b = 64'sd1 <<< 30;
      r.px = 32'(longint'(seg_start[0]) + blend_scale(longint'(seg_goal[0]) - seg_start[0], b));
      r.py = 32'(longint'(seg_start[1]) + blend_scale(longint'(seg_goal[1]) - seg_start[1], b));
      r.pz = 32'(longint'(seg_start[2]) + blend_scale(longint'(seg_goal[2]) - seg_start[2], b));
      if (seg_yaw_blend) begin
         yaw = longint'(seg_start_yaw)
               + blend_scale(fold_heading(longint'(seg_goal_yaw) - seg_start_yaw), b);
      end else begin
         yaw = seg_goal_yaw;
      end
      r.hd     = 16'(yaw);
      r.fin    = (req_sample_time >= seg_dur);
      r.loaded = 1'b1;
      r.dur    = seg_dur;
      return r;
   endfunction

   function automatic bit same_sample(input sample_type e);
      return e.px == rsp_pos_x && e.py == rsp_pos_y && e.pz == rsp_pos_z
          && e.hd == rsp_heading_out && e.fin == rsp_finished
          && e.loaded == rsp_segment_loaded && e.dur == rsp_duration_out;
   endfunction

   always @(posedge clock) begin
      sample_type e;
      if (reset) begin
         speed_reg      = 32'd65536;
         accel_reg      = 32'd131072;
         yaw_rate_reg   = 32'd65536;
         min_time_reg   = '0;
         max_time_reg   = '0;
         heading_en_reg = 1'b1;
         for (int k = 0; k < 3; k++) begin
            seg_start[k] = '0;
            seg_goal[k]  = '0;
         end
         seg_start_yaw = '0;
         seg_goal_yaw  = '0;
         seg_dur       = '0;
         seg_live      = 1'b0;
         seg_yaw_blend = 1'b0;
         sample_q.delete();
         mismatches = 0;
      end else begin
         if (csr_wr_en) begin
            case (csr_index)
               mjss_pkg::CSR_NOMINAL_SPEED:    speed_reg = csr_wr_data;
               mjss_pkg::CSR_MAX_ACCEL:        accel_reg = csr_wr_data;
               mjss_pkg::CSR_MAX_HEADING_RATE: yaw_rate_reg = csr_wr_data;
               mjss_pkg::CSR_MIN_SEG_TIME:     min_time_reg = csr_wr_data;
               mjss_pkg::CSR_MAX_SEG_TIME:     max_time_reg = csr_wr_data;
               mjss_pkg::CSR_HEADING_EN:       heading_en_reg = csr_wr_data[0];
               default: ;
            endcase
         end
         if (req_valid && req_ready) sample_q.push_back(predict_sample());
         if (rsp_valid && rsp_ready) begin
            if (sample_q.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) $display("unexpected response at %0t", $realtime);
            end else begin
               e = sample_q.pop_front();
               if (!same_sample(e)) begin
                  mismatches++;
                  if (mismatches <= 10) begin
                     $display("mismatch at %0t: exp pos %0d %0d %0d yaw %0d fin %0b ld %0b dur %0d",
                              $realtime, e.px, e.py, e.pz, e.hd, e.fin, e.loaded, e.dur);
                     $display("                 got pos %0d %0d %0d yaw %0d fin %0b ld %0b dur %0d",
                              rsp_pos_x, rsp_pos_y, rsp_pos_z, rsp_heading_out,
                              rsp_finished, rsp_segment_loaded, rsp_duration_out);
                  end
               end
            end
         end
      end
      fail_count <= mismatches;
      pending    <= sample_q.size();
   end

endmodule

@@ dv/min_jerk_segment_sampler_unit_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// min_jerk_segment_sampler_unit_tb
// Drives directed and random segment loads and samples through several
// register settings with bursty requests and a stalling receiver; the
// checker beside the block predicts and compares every response.
// ----------------------------------------------------------------------------
module min_jerk_segment_sampler_unit_tb;

   localparam int CYCLE_LIMIT = 3_000_000;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_ready;
   logic               req_action = mjss_pkg::ACT_SAMPLE;
   logic [31:0]        req_sample_time = '0;
   logic signed [31:0] req_start_x = '0, req_start_y = '0, req_start_z = '0;
   logic signed [14:0] req_start_heading = '0;
   logic signed [31:0] req_goal_x = '0, req_goal_y = '0, req_goal_z = '0;
   logic signed [14:0] req_goal_heading = '0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic signed [31:0] rsp_pos_x, rsp_pos_y, rsp_pos_z;
   logic signed [15:0] rsp_heading_out;
   logic               rsp_finished, rsp_segment_loaded;
   logic [31:0]        rsp_duration_out;
   logic               csr_wr_en = 1'b0;
   logic [2:0]         csr_index = mjss_pkg::CSR_NOMINAL_SPEED;
   logic [31:0]        csr_wr_data = '0;
   int                 fail_count, pending;
   int                 cycle_count = 0;
   int                 stall_mode = 0;

   typedef struct {
      logic               act;
      logic [31:0]        t;
      logic signed [31:0] s[3];
      logic signed [31:0] g[3];
      logic signed [14:0] sh, gh;
   } waypoint_req_type;

   always #5 clock = ~clock;

   min_jerk_segment_sampler_unit uut (.*);
   min_jerk_segment_sampler_unit_checker chk (.*);

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("min_jerk_segment_sampler_unit regression: fail");
         $finish;
      end
   end

   // receiver: the stall pattern is redrawn from four modes; one long hold-off fills the block
   always @(posedge clock) begin
      if (cycle_count % 256 == 0) stall_mode <= $urandom_range(0, 3);
      if (cycle_count >= 30000 && cycle_count < 33000) begin
         rsp_ready <= 1'b0;
      end else begin
         case (stall_mode)
            0: rsp_ready <= 1'b1;
            1: rsp_ready <= ($urandom_range(0, 3) != 0);
            2: rsp_ready <= ($urandom_range(0, 3) == 0);
            default: rsp_ready <= (cycle_count % 7 < 3);
         endcase
      end
   end

   task automatic send_waypoint(input waypoint_req_type w);
      req_action        <= w.act;
      req_sample_time   <= w.t;
      req_start_x       <= w.s[0];
      req_start_y       <= w.s[1];
      req_start_z       <= w.s[2];
      req_start_heading <= w.sh;
      req_goal_x        <= w.g[0];
      req_goal_y        <= w.g[1];
      req_goal_z        <= w.g[2];
      req_goal_heading  <= w.gh;
      req_valid         <= 1'b1;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   task automatic idle_gap(input int n);
      if (n > 0) begin
         req_valid <= 1'b0;
         repeat (n) @(posedge clock);
      end
   endtask

   task automatic drain_responses();
      idle_gap(1);
      while (pending != 0) @(posedge clock);
   endtask

   task automatic csr_write(input logic [2:0] idx, input logic [31:0] data);
      csr_wr_en   <= 1'b1;
      csr_index   <= idx;
      csr_wr_data <= data;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      @(posedge clock);
   endtask

   function automatic logic signed [14:0] rand_yaw();
      if ($urandom_range(0, 9) == 0) return 15'($urandom);
      return 15'($signed($urandom_range(0, 25736)) - 12868);
   endfunction

   function automatic logic [31:0] rand_time();
      case ($urandom_range(0, 9))
         0: return '0;
         1: return 32'hFFFF_FFFF;
         2: return $urandom;
         default: return $urandom_range(0, 32'h0008_0000);
      endcase
   endfunction

   function automatic waypoint_req_type rand_waypoint(input logic act);
      waypoint_req_type w;
      logic             wide;
      wide  = ($urandom_range(0, 7) == 0);
      w.act = act;
      w.t   = rand_time();
      for (int k = 0; k < 3; k++) begin
         w.s[k] = $urandom;
         w.g[k] = wide ? 32'($urandom)
                       : w.s[k] + $signed($urandom_range(0, 32'h000C_0000)) - 32'sh0006_0000;
      end
      w.sh = rand_yaw();
      w.gh = rand_yaw();
      return w;
   endfunction

   task automatic directed_items();
      waypoint_req_type w;
      w = '{mjss_pkg::ACT_SAMPLE, 32'd1000, '{0, 0, 0}, '{0, 0, 0}, 15'sd0, 15'sd0};
      send_waypoint(w);                         // no segment yet
      w.act = mjss_pkg::ACT_LOAD; w.t = 0;
      send_waypoint(w);                         // zero distance, floor duration
      w.act = mjss_pkg::ACT_SAMPLE; w.t = 32'd13107;
      send_waypoint(w);                         // exactly at end
      w.t = 32'd6553;
      send_waypoint(w);
      w = '{mjss_pkg::ACT_LOAD, 32'd0, '{32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000},
            '{32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF}, -15'sd16384, 15'sd16383};
      send_waypoint(w);                         // longest distance, yaw beyond pi
      w.act = mjss_pkg::ACT_SAMPLE;
      w.t = 32'h7FFF_FFFF; send_waypoint(w);
      w.t = 32'hFFFF_FFFF; send_waypoint(w);
      w = '{mjss_pkg::ACT_LOAD, 32'h0001_0000, '{32'sh0001_0000, -32'sh0002_0000, 32'sh0}, '{
            -32'sh0003_0000, 32'sh0004_0000, 32'sh0000_8000}, 15'sd12000, -15'sd12000};
      send_waypoint(w);                         // yaw change wraps through pi
      w.act = mjss_pkg::ACT_SAMPLE;
      for (int i = 0; i < 6; i++) begin
         w.t = i * 32'h0001_8000;
         send_waypoint(w);
      end
      w = '{mjss_pkg::ACT_LOAD, 32'h0000_4000, '{32'sh0, 32'sh0, 32'sh0},
            '{32'sh0, 32'sh0, 32'sh0}, 15'sd12868, -15'sd12868};
      send_waypoint(w);                         // pure yaw segment at plus and minus pi
      w = '{mjss_pkg::ACT_LOAD, 32'h0000_8000, '{32'sh7FFF_FFFF, 32'sh0, -32'sh1},
            '{32'sh7FFF_0000, 32'sh1, 32'sh0}, 15'sd0, 15'sd5};
      send_waypoint(w);
   endtask

   // register settings per phase: speed, accel, yaw rate, min time, max time, yaw enable
   logic [31:0] phase_csr[6][6] = '{
      '{32'd65536, 32'd131072, 32'd65536, 32'd0, 32'd0, 32'd1},
      '{32'd66, 32'd66, 32'd66, 32'd0, 32'd0, 32'd0},
      '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd0, 32'd100, 32'd1},
      '{32'd300000, 32'd20000, 32'd200, 32'hFFFF_FFFF, 32'd0, 32'd1},
      '{32'd5000, 32'd7000, 32'd3000, 32'h0003_0000, 32'h0005_0000, 32'd0},
      '{32'd40000, 32'd90000, 32'd50000, 32'd20000, 32'hFFFF_FFFF, 32'd1}
   };

   initial begin
      waypoint_req_type w;
      int               sent, burst;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      directed_items();
      sent = 0;
      for (int ph = 0; ph < 6; ph++) begin
         drain_responses();
         repeat (300) @(posedge clock);
         for (int r = 0; r < 6; r++) csr_write(3'(r), phase_csr[ph][r]);
         burst = $urandom_range(1, 30);
         while (sent < (ph + 1) * 320) begin
            // mostly a load followed by samples along it; sometimes a stray sample
            if ($urandom_range(0, 4) == 0 || sent % 6 == 0) begin
               w = rand_waypoint(mjss_pkg::ACT_LOAD);
            end else begin
               w.act = mjss_pkg::ACT_SAMPLE;
               w.t   = rand_time();
               if ($urandom_range(0, 9) == 0) w = rand_waypoint(mjss_pkg::ACT_SAMPLE);
            end
            send_waypoint(w);
            sent++;
            burst--;
            if (burst == 0) begin
               burst = $urandom_range(1, 30);
               idle_gap($urandom_range(0, 20));
            end
         end
      end
      drain_responses();
      repeat (400) @(posedge clock);
      if (fail_count == 0) begin
         $display("min_jerk_segment_sampler_unit regression: pass");
      end else begin
         $display("min_jerk_segment_sampler_unit regression: fail");
      end
      $finish;
   end

endmodule

@@ sim.f @@
hdl/mjss_pkg.sv
hdl/mjss_mul.sv
hdl/mjss_divsqrt.sv
hdl/min_jerk_segment_sampler_unit.sv
dv/min_jerk_segment_sampler_unit_checker.sv
dv/min_jerk_segment_sampler_unit_tb.sv
